// File: rtl/mpsc_pkg.sv
package mpsc_pkg;

   localparam logic [15:0] SCALE_MIN_POS        = 16'd128;
   localparam logic [15:0] SCALE_MAX_POS        = 16'd65407;
   localparam logic [15:0] TAKEOVER_COUNTS      = 16'd64;
   localparam logic [15:0] MOTION_TIMEOUT       = 16'd2000;
   localparam logic [15:0] REVERSAL_COAST_TICKS = 16'd5;
   localparam logic [9:0]  DUTY_FULL            = 10'd1000;

   localparam int DIVIDEND_W = 26;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   typedef enum logic [1:0] {
      DRV_COAST = 2'd0,
      DRV_UP    = 2'd1,
      DRV_DOWN  = 2'd2
   } drive_type;

   localparam logic [4:0] F_CONFIG  = 5'b00001;
   localparam logic [4:0] F_SENSOR  = 5'b00010;
   localparam logic [4:0] F_DRIVER  = 5'b00100;
   localparam logic [4:0] F_STALL   = 5'b01000;
   localparam logic [4:0] F_TIMEOUT = 5'b10000;

   typedef enum logic [2:0] {
      REG_SOFT_MIN      = 3'd0,
      REG_SOFT_MAX      = 3'd1,
      REG_DEADBAND      = 3'd2,
      REG_APPROACH_SPAN = 3'd3,
      REG_MIN_DUTY      = 3'd4,
      REG_MAX_DUTY      = 3'd5,
      REG_CURRENT_LIMIT = 3'd6,
      REG_STALL_LIMIT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] lo_limit_pos;
      logic [15:0] hi_limit_pos;
      logic [15:0] deadband;
      logic [15:0] approach_span;
      logic [9:0]  min_duty;
      logic [9:0]  max_duty;
      logic [15:0] current_limit;
      logic [15:0] stall_limit;
   } cfg_type;

   function automatic logic [15:0] clamp_pos(input cfg_type cfg, input logic [15:0] p);
      logic [15:0] r;
      if (p < cfg.lo_limit_pos) r = cfg.lo_limit_pos;
      else if (p > cfg.hi_limit_pos) r = cfg.hi_limit_pos;
      else r = p;
      return r;
   endfunction

   function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic sensor_ok(input logic [15:0] p);
      return (p >= SCALE_MIN_POS) && (p <= SCALE_MAX_POS);
   endfunction

   function automatic logic regs_ok(input cfg_type cfg);
      return (SCALE_MIN_POS < cfg.lo_limit_pos)
         && (cfg.lo_limit_pos < cfg.hi_limit_pos)
         && (cfg.hi_limit_pos < SCALE_MAX_POS)
         && (cfg.deadband != 16'd0)
         && (cfg.approach_span > cfg.deadband)
         && (TAKEOVER_COUNTS > cfg.deadband)
         && (cfg.min_duty != 10'd0)
         && (cfg.min_duty <= cfg.max_duty)
         && (cfg.max_duty <= DUTY_FULL)
         && (cfg.current_limit != 16'd0)
         && (cfg.stall_limit != 16'd0)
         && (MOTION_TIMEOUT > cfg.stall_limit);
   endfunction

endpackage

// File: rtl/mpsc_csr.sv
module mpsc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output mpsc_pkg::cfg_type cfg
);
   import mpsc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lo_limit_pos      <= 16'd256;
         cfg_ff.hi_limit_pos      <= 16'd65279;
         cfg_ff.deadband          <= 16'd8;
         cfg_ff.approach_span     <= 16'd512;
         cfg_ff.min_duty          <= 10'd200;
         cfg_ff.max_duty          <= 10'd1000;
         cfg_ff.current_limit     <= 16'd500;
         cfg_ff.stall_limit       <= 16'd20;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_SOFT_MIN:      cfg_ff.lo_limit_pos      <= csr_data;
            REG_SOFT_MAX:      cfg_ff.hi_limit_pos      <= csr_data;
            REG_DEADBAND:      cfg_ff.deadband          <= csr_data;
            REG_APPROACH_SPAN: cfg_ff.approach_span     <= csr_data;
            REG_MIN_DUTY:      cfg_ff.min_duty          <= csr_data[9:0];
            REG_MAX_DUTY:      cfg_ff.max_duty          <= csr_data[9:0];
            REG_CURRENT_LIMIT: cfg_ff.current_limit     <= csr_data;
            REG_STALL_LIMIT:   cfg_ff.stall_limit       <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/mpsc_div.sv
module mpsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mpsc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [15:0]                       divisor,
   output logic                              done,
   output logic [9:0]                        quotient
);
   import mpsc_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [15:0]           rem_ff;
   logic [16:0]           trial;
   logic                  fits;

   // restoring division, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits     = trial >= {1'b0, divisor};
   assign done     = done_ff;
   assign quotient = quo_ff[9:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= 16'd0;
         cnt_ff <= STEP_W'(DIVIDEND_W - 1);
      end else if (busy_ff) begin
         rem_ff <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> done_ff) else $error("divider missed done");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held over two cycles");

endmodule

// File: rtl/motorized_pot_servo_controller_unit.sv
// Motorized potentiometer servo controller.
// Input channel req_*: one item per control tick (req_action 0) or an
// initialise (req_action 1). An item is taken when req_valid is high and
// req_stall low; req_stall is high from the cycle after acceptance until
// the item's result has been loaded into the output register.
// Result channel rsp_*: exactly one result per item, held in an output
// register until taken (rsp_valid high, rsp_stall low). A waiting result
// does not block the next item; only a second finished result waits for it.
// Without a duty ramp an item passes ST_EVAL and then ST_OUT; when the
// duty ramp is needed it waits in ST_DIV between them. The ramp quotient
// comes from a restoring divider giving one quotient bit per cycle over a
// 26-bit dividend. A new item is taken only once the last result is in
// the output register, and ST_OUT can wait while a result is not taken.
// csr_*: register writes, always ready, index = register number 0 to 7.
// Reset (synchronous, active high) restores register defaults, clears the
// servo state (unconfigured, no faults, coast) and empties the output.
module motorized_pot_servo_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_measured_position,
   input  logic        req_new_target,
   input  logic [15:0] req_commanded_target,
   input  logic [15:0] req_motor_current,
   input  logic        req_drv_fault,
   input  logic        req_clear_request,
   input  logic        req_manual_override,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_drive,
   output logic [9:0]  rsp_duty,
   output logic [15:0] rsp_target_now,
   output logic [4:0]  rsp_faults,
   output logic [31:0] rsp_motor_ticks,
   output logic        rsp_moving,
   output logic        rsp_target_moved,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mpsc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DIV, ST_OUT} state_type;

   cfg_type   cfg;
   state_type state_ff;

   logic        in_action_ff, in_tvalid_ff, in_dfault_ff, in_clr_ff, in_manual_ff;
   logic [15:0] in_pos_ff, in_cmd_ff, in_cur_ff;

   logic        configured_ff, configured_in;
   logic [15:0] held_target_ff, held_target_in;
   drive_type   drive_ff, drive_in;
   logic [4:0]  fault_ff, fault_in;
   logic [15:0] motion_ff, motion_in;
   logic [15:0] overcur_ff, overcur_in;
   logic [15:0] rev_wait_ff, rev_wait_in;
   logic        pending_ff, pending_in;
   logic [31:0] total_ff, total_in;

   logic        changed, go_ramp, go_div;
   logic [15:0] err, span_err;
   logic [9:0]  ramp_span;
   logic [25:0] product;
   logic        div_done;
   logic [9:0]  div_q;

   logic        res_changed_ff;
   logic [9:0]  res_duty_ff;

   logic        rsp_valid_ff, rsp_moving_ff, rsp_changed_ff;
   logic [1:0]  rsp_drive_ff;
   logic [9:0]  rsp_duty_ff;
   logic [15:0] rsp_target_ff;
   logic [4:0]  rsp_faults_ff;
   logic [31:0] rsp_ticks_ff;
   logic        out_free;

   mpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_div),
      .dividend (product),
      .divisor  (cfg.approach_span),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go_div    = (state_ff == ST_EVAL) && go_ramp;
   assign ramp_span = (cfg.max_duty > cfg.min_duty) ? (cfg.max_duty - cfg.min_duty) : 10'd0;
   assign product   = {16'd0, ramp_span} * {10'd0, span_err};

   always_comb begin
      logic        pos_ok, safe;
      logic [15:0] cpos, ccmd, oc_next, mot_next;
      logic [4:0]  flt_a;
      drive_type   want;

      configured_in  = configured_ff;
      held_target_in = held_target_ff;
      drive_in       = drive_ff;
      fault_in       = fault_ff;
      motion_in      = motion_ff;
      overcur_in     = overcur_ff;
      rev_wait_in    = rev_wait_ff;
      pending_in     = pending_ff;
      total_in       = total_ff;
      changed        = 1'b0;
      go_ramp        = 1'b0;
      err            = 16'd0;
      span_err       = 16'd0;

      pos_ok  = sensor_ok(in_pos_ff);
      cpos    = clamp_pos(cfg, in_pos_ff);
      ccmd    = clamp_pos(cfg, in_cmd_ff);
      safe    = pos_ok && !in_dfault_ff && (in_cur_ff <= cfg.current_limit) && !in_manual_ff;
      flt_a   = fault_ff | (pos_ok ? 5'd0 : F_SENSOR) | (in_dfault_ff ? F_DRIVER : 5'd0);
      oc_next = (in_cur_ff > cfg.current_limit)
                ? ((overcur_ff != 16'hFFFF) ? overcur_ff + 16'd1 : overcur_ff) : 16'd0;
      mot_next = (motion_ff != 16'hFFFF) ? motion_ff + 16'd1 : motion_ff;
      want     = DRV_COAST;

      if (in_action_ff) begin
         configured_in  = 1'b0;
         held_target_in = 16'd0;
         drive_in       = DRV_COAST;
         fault_in       = 5'd0;
         motion_in      = 16'd0;
         overcur_in     = 16'd0;
         rev_wait_in    = 16'd0;
         pending_in     = 1'b0;
         total_in       = 32'd0;
         if (!regs_ok(cfg)) begin
            fault_in = F_CONFIG;
         end else if (!pos_ok) begin
            fault_in = F_SENSOR;
         end else begin
            held_target_in = cpos;
            configured_in  = 1'b1;
         end
      end else if (!configured_ff) begin
         drive_in = DRV_COAST;
         fault_in = fault_ff | F_CONFIG;
      end else if (in_clr_ff) begin
         drive_in    = DRV_COAST;
         motion_in   = 16'd0;
         overcur_in  = 16'd0;
         rev_wait_in = 16'd0;
         fault_in    = flt_a;
         if (safe) begin
            fault_in       = 5'd0;
            changed        = cpos != held_target_ff;
            held_target_in = cpos;
            pending_in     = 1'b0;
         end
      end else if (flt_a != 5'd0) begin
         fault_in    = flt_a;
         drive_in    = DRV_COAST;
         motion_in   = 16'd0;
         rev_wait_in = 16'd0;
      end else if (in_manual_ff) begin
         changed        = cpos != held_target_ff;
         held_target_in = cpos;
         pending_in     = 1'b0;
         drive_in       = DRV_COAST;
         motion_in      = 16'd0;
         overcur_in     = 16'd0;
         rev_wait_in    = 16'd0;
      end else begin
         if (in_tvalid_ff) begin
            changed        = ccmd != held_target_ff;
            held_target_in = ccmd;
            pending_in     = 1'b1;
         end else if (drive_ff == DRV_COAST && rev_wait_ff == 16'd0 && !pending_ff
                      && abs_diff(in_pos_ff, held_target_ff) >= TAKEOVER_COUNTS) begin
            changed        = cpos != held_target_ff;
            held_target_in = cpos;
            pending_in     = 1'b0;
         end
         err  = abs_diff(in_pos_ff, held_target_in);
         want = (held_target_in > in_pos_ff) ? DRV_UP : DRV_DOWN;
         if (err <= cfg.deadband) begin
            drive_in    = DRV_COAST;
            motion_in   = 16'd0;
            overcur_in  = 16'd0;
            rev_wait_in = 16'd0;
            pending_in  = 1'b0;
         end else if (rev_wait_ff != 16'd0) begin
            rev_wait_in = rev_wait_ff - 16'd1;
            drive_in    = DRV_COAST;
         end else if (drive_ff != DRV_COAST && drive_ff != want) begin
            drive_in    = DRV_COAST;
            rev_wait_in = REVERSAL_COAST_TICKS;
         end else begin
            overcur_in = oc_next;
            if (oc_next >= cfg.stall_limit) begin
               fault_in    = fault_ff | F_STALL;
               drive_in    = DRV_COAST;
               motion_in   = 16'd0;
               rev_wait_in = 16'd0;
            end else begin
               motion_in = mot_next;
               if (mot_next >= MOTION_TIMEOUT) begin
                  fault_in    = fault_ff | F_TIMEOUT;
                  drive_in    = DRV_COAST;
                  rev_wait_in = 16'd0;
               end else begin
                  drive_in = want;
                  total_in = (total_ff != 32'hFFFF_FFFF) ? total_ff + 32'd1 : total_ff;
                  go_ramp  = err < cfg.approach_span;
                  span_err = err;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_pos_ff    <= req_measured_position;
         in_tvalid_ff <= req_new_target;
         in_cmd_ff    <= req_commanded_target;
         in_cur_ff    <= req_motor_current;
         in_dfault_ff <= req_drv_fault;
         in_clr_ff    <= req_clear_request;
         in_manual_ff <= req_manual_override;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         configured_ff  <= 1'b0;
         held_target_ff <= 16'd0;
         drive_ff       <= DRV_COAST;
         fault_ff       <= 5'd0;
         motion_ff      <= 16'd0;
         overcur_ff     <= 16'd0;
         rev_wait_ff    <= 16'd0;
         pending_ff     <= 1'b0;
         total_ff       <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               configured_ff  <= configured_in;
               held_target_ff <= held_target_in;
               drive_ff       <= drive_in;
               fault_ff       <= fault_in;
               motion_ff      <= motion_in;
               overcur_ff     <= overcur_in;
               rev_wait_ff    <= rev_wait_in;
               pending_ff     <= pending_in;
               total_ff       <= total_in;
               res_changed_ff <= changed;
               res_duty_ff    <= (drive_in == DRV_COAST) ? 10'd0 : cfg.max_duty;
               state_ff       <= go_ramp ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
               if (div_done) begin
                  res_duty_ff <= 10'(cfg.min_duty + div_q);
                  state_ff    <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_drive_ff   <= drive_ff;
                  rsp_moving_ff  <= drive_ff != DRV_COAST;
                  rsp_duty_ff    <= res_duty_ff;
                  rsp_target_ff  <= held_target_ff;
                  rsp_faults_ff  <= fault_ff;
                  rsp_ticks_ff   <= total_ff;
                  rsp_changed_ff <= res_changed_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive          = rsp_drive_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_target_now     = rsp_target_ff;
   assign rsp_faults         = rsp_faults_ff;
   assign rsp_motor_ticks    = rsp_ticks_ff;
   assign rsp_moving         = rsp_moving_ff;
   assign rsp_target_moved   = rsp_changed_ff;

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_EVAL) else $error("item not evaluated");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider result outside ramp step");
   a_coast_no_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_moving) |-> rsp_duty == 10'd0) else $error("duty while coasting");
   a_moving_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_moving == (rsp_drive != DRV_COAST))) else $error("moving flag mismatch");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import mpsc_pkg::*;

   typedef struct packed {
      logic        action;
      logic [15:0] position;
      logic        new_target;
      logic [15:0] target;
      logic [15:0] current;
      logic        drv_fault;
      logic        clear;
      logic        manual;
   } tick_cmd_type;

   typedef struct packed {
      drive_type   drive;
      logic [9:0]  duty;
      logic [15:0] target_now;
      logic [4:0]  faults;
      logic [31:0] motor_ticks;
      logic        moving;
      logic        target_moved;
   } drive_report_type;

   localparam cfg_type RESET_REGS = '{16'd256, 16'd65279, 16'd8, 16'd512,
                                      10'd200, 10'd1000, 16'd500, 16'd20};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [15:0] req_measured_position = 16'd0;
   logic        req_new_target = 1'b0;
   logic [15:0] req_commanded_target = 16'd0;
   logic [15:0] req_motor_current = 16'd0;
   logic        req_drv_fault = 1'b0;
   logic        req_clear_request = 1'b0;
   logic        req_manual_override = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_drive;
   logic [9:0]  rsp_duty;
   logic [15:0] rsp_target_now;
   logic [4:0]  rsp_faults;
   logic [31:0] rsp_motor_ticks;
   logic        rsp_moving;
   logic        rsp_target_moved;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_SOFT_MIN;
   logic [15:0] csr_data = 16'd0;

   motorized_pot_servo_controller_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_measured_position(req_measured_position),
      .req_new_target      (req_new_target),
      .req_commanded_target(req_commanded_target),
      .req_motor_current   (req_motor_current),
      .req_drv_fault       (req_drv_fault),
      .req_clear_request   (req_clear_request),
      .req_manual_override (req_manual_override),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive           (rsp_drive),
      .rsp_duty            (rsp_duty),
      .rsp_target_now      (rsp_target_now),
      .rsp_faults          (rsp_faults),
      .rsp_motor_ticks     (rsp_motor_ticks),
      .rsp_moving          (rsp_moving),
      .rsp_target_moved    (rsp_target_moved),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // servo state as the block should hold it
   cfg_type      regs;
   logic         armed;
   logic [15:0]  goal;
   drive_type    motor_dir;
   logic [4:0]   fault_latch;
   logic [15:0]  run_ticks;
   logic [15:0]  hot_ticks;
   logic [15:0]  coast_left;
   logic         goal_fresh;
   logic [31:0]  drive_total;

   drive_report_type drive_reports_due[$];
   drive_report_type due;
   int            mismatches = 0;
   int            burst_left = 0;
   logic [15:0]   dial;
   bit [31:0]     cycle_no = 0;

   function automatic logic [15:0] soft_clamp(input logic [15:0] p);
      return (p < regs.lo_limit_pos) ? regs.lo_limit_pos :
             (p > regs.hi_limit_pos) ? regs.hi_limit_pos : p;
   endfunction

   function automatic logic [15:0] distance(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic on_scale(input logic [15:0] p);
      return p >= SCALE_MIN_POS && p <= SCALE_MAX_POS;
   endfunction

   function automatic logic regs_sane();
      return (regs.lo_limit_pos > SCALE_MIN_POS)
         && (regs.hi_limit_pos > regs.lo_limit_pos)
         && (regs.hi_limit_pos < SCALE_MAX_POS)
         && (regs.deadband > 16'd0)
         && (regs.approach_span > regs.deadband)
         && (regs.deadband < TAKEOVER_COUNTS)
         && (regs.min_duty > 10'd0)
         && (regs.max_duty >= regs.min_duty)
         && (regs.max_duty <= DUTY_FULL)
         && (regs.current_limit > 16'd0)
         && (regs.stall_limit > 16'd0)
         && (regs.stall_limit < MOTION_TIMEOUT);
   endfunction

   function automatic logic [9:0] ramp(input logic [15:0] err);
      logic [31:0] rise;
      if (err >= regs.approach_span) return regs.max_duty;
      rise = (regs.max_duty > regs.min_duty) ? 32'(regs.max_duty - regs.min_duty) : 32'd0;
      return 10'(32'(regs.min_duty) + rise * 32'(err) / 32'(regs.approach_span));
   endfunction

   function automatic void clear_servo();
      armed = 1'b0;
      goal = 16'd0;
      motor_dir = DRV_COAST;
      fault_latch = 5'd0;
      run_ticks = 16'd0;
      hot_ticks = 16'd0;
      coast_left = 16'd0;
      goal_fresh = 1'b0;
      drive_total = 32'd0;
   endfunction

   function automatic logic retarget(input logic [15:0] t);
      logic moved;
      moved = (t != goal);
      goal = t;
      return moved;
   endfunction

   function automatic drive_report_type make_report(input logic changed,
                                                    input logic [9:0] duty);
      drive_report_type r;
      r.drive = motor_dir;
      r.moving = (motor_dir != DRV_COAST);
      r.duty = r.moving ? duty : 10'd0;
      r.target_now = goal;
      r.faults = fault_latch;
      r.motor_ticks = drive_total;
      r.target_moved = changed;
      return r;
   endfunction

   function automatic drive_report_type apply_tick(input tick_cmd_type c);
      logic        changed;
      logic        pos_ok;
      logic [15:0] err;
      drive_type   want;
      changed = 1'b0;
      if (c.action) begin
         clear_servo();
         if (!regs_sane()) fault_latch = F_CONFIG;
         else if (!on_scale(c.position)) fault_latch = F_SENSOR;
         else begin
            goal = soft_clamp(c.position);
            armed = 1'b1;
         end
         return make_report(1'b0, 10'd0);
      end
      if (!armed) begin
         motor_dir = DRV_COAST;
         fault_latch |= F_CONFIG;
         return make_report(1'b0, 10'd0);
      end
      pos_ok = on_scale(c.position);
      if (!pos_ok) fault_latch |= F_SENSOR;
      if (c.drv_fault) fault_latch |= F_DRIVER;
      if (c.clear) begin
         motor_dir = DRV_COAST;
         run_ticks = 16'd0;
         hot_ticks = 16'd0;
         coast_left = 16'd0;
         if (pos_ok && !c.drv_fault && c.current <= regs.current_limit && !c.manual) begin
            fault_latch = 5'd0;
            changed = retarget(soft_clamp(c.position));
            goal_fresh = 1'b0;
         end
         return make_report(changed, 10'd0);
      end
      if (fault_latch != 5'd0) begin
         motor_dir = DRV_COAST;
         run_ticks = 16'd0;
         coast_left = 16'd0;
         return make_report(1'b0, 10'd0);
      end
      if (c.manual) begin
         changed = retarget(soft_clamp(c.position));
         goal_fresh = 1'b0;
         motor_dir = DRV_COAST;
         run_ticks = 16'd0;
         hot_ticks = 16'd0;
         coast_left = 16'd0;
         return make_report(changed, 10'd0);
      end
      if (c.new_target) begin
         changed = retarget(soft_clamp(c.target));
         goal_fresh = 1'b1;
      end else if (motor_dir == DRV_COAST && coast_left == 16'd0 && !goal_fresh
                   && distance(c.position, goal) >= TAKEOVER_COUNTS) begin
         changed = retarget(soft_clamp(c.position));
         goal_fresh = 1'b0;
      end
      err = distance(c.position, goal);
      if (err <= regs.deadband) begin
         motor_dir = DRV_COAST;
         run_ticks = 16'd0;
         hot_ticks = 16'd0;
         coast_left = 16'd0;
         goal_fresh = 1'b0;
         return make_report(changed, 10'd0);
      end
      want = (goal > c.position) ? DRV_UP : DRV_DOWN;
      if (coast_left != 16'd0) begin
         coast_left = coast_left - 16'd1;
         motor_dir = DRV_COAST;
         return make_report(changed, 10'd0);
      end
      if (motor_dir != DRV_COAST && motor_dir != want) begin
         motor_dir = DRV_COAST;
         coast_left = REVERSAL_COAST_TICKS;
         return make_report(changed, 10'd0);
      end
      if (c.current > regs.current_limit) begin
         if (hot_ticks != 16'hFFFF) hot_ticks = hot_ticks + 16'd1;
      end else begin
         hot_ticks = 16'd0;
      end
      if (hot_ticks >= regs.stall_limit) begin
         fault_latch |= F_STALL;
         motor_dir = DRV_COAST;
         run_ticks = 16'd0;
         coast_left = 16'd0;
         return make_report(changed, 10'd0);
      end
      if (run_ticks != 16'hFFFF) run_ticks = run_ticks + 16'd1;
      if (run_ticks >= MOTION_TIMEOUT) begin
         fault_latch |= F_TIMEOUT;
         motor_dir = DRV_COAST;
         coast_left = 16'd0;
         return make_report(changed, 10'd0);
      end
      motor_dir = want;
      if (drive_total != 32'hFFFF_FFFF) drive_total = drive_total + 32'd1;
      return make_report(changed, ramp(err));
   endfunction

   function automatic void compare_field(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("item with none expected: drive %0d target %0d faults %0d",
                        rsp_drive, rsp_target_now, rsp_faults);
         end else begin
            due = drive_reports_due.pop_front();
            compare_field("drive", 32'(due.drive), 32'(rsp_drive));
            compare_field("duty", 32'(due.duty), 32'(rsp_duty));
            compare_field("target_now", 32'(due.target_now), 32'(rsp_target_now));
            compare_field("faults", 32'(due.faults), 32'(rsp_faults));
            compare_field("motor_ticks", due.motor_ticks, rsp_motor_ticks);
            compare_field("moving", 32'(due.moving), 32'(rsp_moving));
            compare_field("target_moved", 32'(due.target_moved), 32'(rsp_target_moved));
         end
      end
   end

   // receiver back-pressure, its character chosen by bits 10:9 of cycle_no
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      case (cycle_no[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 1) == 0);
         2'd2: rsp_stall <= ((cycle_no % 11) < 4);
         default: rsp_stall <= ($urandom_range(0, 5) == 0);
      endcase
   end

   task automatic send_item(input tick_cmd_type c);
      req_valid <= 1'b1;
      req_action <= c.action;
      req_measured_position <= c.position;
      req_new_target <= c.new_target;
      req_commanded_target <= c.target;
      req_motor_current <= c.current;
      req_drv_fault <= c.drv_fault;
      req_clear_request <= c.clear;
      req_manual_override <= c.manual;
      do @(posedge clock); while (req_stall);
      drive_reports_due.push_back(apply_tick(c));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_quiet();
      if (req_valid) req_valid <= 1'b0;
      while (drive_reports_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SOFT_MIN:      regs.lo_limit_pos = value;
         REG_SOFT_MAX:      regs.hi_limit_pos = value;
         REG_DEADBAND:      regs.deadband = value;
         REG_APPROACH_SPAN: regs.approach_span = value;
         REG_MIN_DUTY:      regs.min_duty = value[9:0];
         REG_MAX_DUTY:      regs.max_duty = value[9:0];
         REG_CURRENT_LIMIT: regs.current_limit = value;
         default:           regs.stall_limit = value;
      endcase
   endtask

   task automatic write_all(input cfg_type r);
      write_reg(REG_SOFT_MIN, r.lo_limit_pos);
      write_reg(REG_SOFT_MAX, r.hi_limit_pos);
      write_reg(REG_DEADBAND, r.deadband);
      write_reg(REG_APPROACH_SPAN, r.approach_span);
      write_reg(REG_MIN_DUTY, 16'(r.min_duty));
      write_reg(REG_MAX_DUTY, 16'(r.max_duty));
      write_reg(REG_CURRENT_LIMIT, r.current_limit);
      write_reg(REG_STALL_LIMIT, r.stall_limit);
   endtask

   function automatic tick_cmd_type tick(input logic [15:0] pos, input logic tv,
                                         input logic [15:0] aim, input logic [15:0] amps);
      tick_cmd_type c;
      c = '0;
      c.position = pos;
      c.new_target = tv;
      c.target = aim;
      c.current = amps;
      return c;
   endfunction

   task automatic send_init(input logic [15:0] pos);
      tick_cmd_type c;
      c = tick(pos, 1'b0, 16'd0, 16'd0);
      c.action = 1'b1;
      send_item(c);
   endtask

   function automatic logic [15:0] hold_on_scale(input int v);
      if (v < int'(SCALE_MIN_POS)) return SCALE_MIN_POS;
      if (v > int'(SCALE_MAX_POS)) return SCALE_MAX_POS;
      return 16'(v);
   endfunction

   function automatic cfg_type random_regs();
      cfg_type r;
      r.lo_limit_pos = 16'($urandom_range(129, 40000));
      r.hi_limit_pos = 16'($urandom_range(r.lo_limit_pos + 16'd1, 65406));
      r.deadband = 16'($urandom_range(1, 63));
      r.approach_span = ($urandom_range(0, 1) == 0) ?
                        16'($urandom_range(r.deadband + 16'd1, 1000)) :
                        16'($urandom_range(r.deadband + 16'd1, 65535));
      r.min_duty = 10'($urandom_range(1, 1000));
      r.max_duty = 10'($urandom_range(r.min_duty, 1000));
      r.current_limit = 16'($urandom_range(1, 3000));
      r.stall_limit = 16'($urandom_range(1, 40));
      return r;
   endfunction

   // the dial follows the predicted drive, with hand jolts and sensor noise
   task automatic random_ticks(input int count, input logic may_init);
      tick_cmd_type c;
      int        n;
      int        reach;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 29) == 0)
            dial = hold_on_scale(int'(dial) + int'($urandom_range(0, 6000)) - 3000);
         c = tick(dial, 1'b0, 16'($urandom), 16'($urandom_range(0, regs.current_limit)));
         if ($urandom_range(0, 9) == 0)
            c.current = 16'($urandom_range(regs.current_limit, 65535));
         if ($urandom_range(0, 19) == 0) begin
            c.new_target = 1'b1;
            if ($urandom_range(0, 1) == 0)
               c.target = hold_on_scale(int'(dial) + int'($urandom_range(0, 4000)) - 2000);
         end
         if ($urandom_range(0, 49) == 0) c.position = 16'($urandom);
         c.drv_fault = ($urandom_range(0, 79) == 0);
         c.manual = ($urandom_range(0, 29) == 0);
         c.clear = ($urandom_range(0, 39) == 0);
         if (armed && fault_latch != 5'd0 && $urandom_range(0, 3) == 0) begin
            c.clear = 1'b1;
            c.position = dial;
            c.drv_fault = 1'b0;
            c.manual = 1'b0;
            c.current = 16'($urandom_range(0, regs.current_limit));
         end
         if (may_init && ((!armed && $urandom_range(0, 2) == 0) || $urandom_range(0, 99) == 0)) begin
            c.action = 1'b1;
            c.position = dial;
         end
         send_item(c);
         reach = int'(distance(dial, goal)) / 2 + 3;
         if (motor_dir == DRV_UP)
            dial = hold_on_scale(int'(dial) + int'($urandom_range(1, reach)));
         else if (motor_dir == DRV_DOWN)
            dial = hold_on_scale(int'(dial) - int'($urandom_range(1, reach)));
      end
   endtask

   task automatic test_unconfigured();
      tick_cmd_type c;
      c = tick(16'd1000, 1'b1, 16'd2000, 16'd0);
      c.clear = 1'b1;
      send_item(c);
      c.clear = 1'b0;
      c.manual = 1'b1;
      c.drv_fault = 1'b1;
      send_item(c);
      send_init(16'd0);
      send_init(16'hFFFF);
      send_init(SCALE_MIN_POS - 16'd1);
      send_init(SCALE_MAX_POS + 16'd1);
      send_init(SCALE_MIN_POS);
   endtask

   task automatic test_servo_directed();
      tick_cmd_type c;
      int        k;
      send_item(tick(16'd264, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd265, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd300, 1'b1, 16'hFFFF, 16'd500));
      send_item(tick(16'd320, 1'b1, 16'd0, 16'd501));
      for (k = 0; k < 6; k++) send_item(tick(16'd320, 1'b0, 16'd0, 16'd0));
      c = tick(16'd40000, 1'b0, 16'd0, 16'd0);
      c.manual = 1'b1;
      send_item(c);
      send_item(tick(16'd40100, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd40163, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd40100, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd40164, 1'b0, 16'd0, 16'd0));
      // sensor out of range, then recovery attempts
      send_item(tick(SCALE_MIN_POS - 16'd1, 1'b0, 16'd0, 16'd0));
      send_item(tick(16'd1000, 1'b0, 16'd0, 16'd0));
      c = tick(16'hFFFF, 1'b0, 16'd0, 16'd0);
      c.clear = 1'b1;
      send_item(c);
      c.position = 16'd1000;
      c.drv_fault = 1'b1;
      send_item(c);
      c.drv_fault = 1'b0;
      c.current = 16'd501;
      send_item(c);
      c.current = 16'd500;
      c.manual = 1'b1;
      send_item(c);
      c.manual = 1'b0;
      send_item(c);
   endtask

   task automatic test_stall_and_timeout();
      tick_cmd_type c;
      int        k;
      send_item(tick(16'd1000, 1'b1, 16'd30000, 16'd600));
      for (k = 0; k < 22; k++) send_item(tick(16'd1000, 1'b0, 16'd0, 16'd600));
      c = tick(16'd1000, 1'b0, 16'd0, 16'd0);
      c.clear = 1'b1;
      send_item(c);
      send_item(tick(16'd1000, 1'b1, 16'd60000, 16'd0));
      for (k = 0; k < 40; k++) send_item(tick(16'd1000, 1'b0, 16'd0, 16'd0));
      send_item(c);
   endtask

   task automatic try_bad_regs(input csr_index_type idx, input logic [15:0] value);
      cfg_type saved;
      saved = regs;
      write_reg(idx, value);
      send_init(16'd1000);
      send_item(tick(16'd1000, 1'b1, 16'd2000, 16'd0));
      write_all(saved);
   endtask

   task automatic test_register_checks();
      write_all(RESET_REGS);
      try_bad_regs(REG_SOFT_MIN, SCALE_MIN_POS);
      try_bad_regs(REG_SOFT_MIN, 16'd0);
      try_bad_regs(REG_SOFT_MIN, 16'd65279);
      try_bad_regs(REG_SOFT_MAX, SCALE_MAX_POS);
      try_bad_regs(REG_SOFT_MAX, 16'hFFFF);
      try_bad_regs(REG_DEADBAND, 16'd0);
      try_bad_regs(REG_DEADBAND, TAKEOVER_COUNTS);
      try_bad_regs(REG_APPROACH_SPAN, 16'd8);
      try_bad_regs(REG_MIN_DUTY, 16'd0);
      try_bad_regs(REG_MAX_DUTY, 16'd100);
      try_bad_regs(REG_MAX_DUTY, 16'd0);
      try_bad_regs(REG_CURRENT_LIMIT, 16'd0);
      try_bad_regs(REG_STALL_LIMIT, 16'd0);
      try_bad_regs(REG_STALL_LIMIT, MOTION_TIMEOUT);
      try_bad_regs(REG_STALL_LIMIT, 16'hFFFF);
      // tightest settings that still pass the init checks
      write_all(cfg_type'{16'd129, 16'd65406, 16'd63, 16'd64, 10'd1000, 10'd1000,
                          16'hFFFF, 16'd1999});
      dial = 16'd5000;
      send_init(dial);
      random_ticks(30, 1'b1);
   endtask

   task automatic test_live_registers();
      write_all(RESET_REGS);
      dial = 16'd5000;
      send_init(dial);
      write_reg(REG_APPROACH_SPAN, 16'd0);
      random_ticks(40, 1'b0);
      write_reg(REG_SOFT_MIN, 16'd50000);
      write_reg(REG_SOFT_MAX, 16'd1000);
      random_ticks(40, 1'b0);
      write_reg(REG_APPROACH_SPAN, 16'd300);
      write_reg(REG_MIN_DUTY, 16'd900);
      write_reg(REG_MAX_DUTY, 16'd100);
      random_ticks(40, 1'b0);
   endtask

   task automatic test_random_servo();
      int k;
      write_all(RESET_REGS);
      send_init(dial);
      random_ticks(200, 1'b1);
      write_all(cfg_type'{16'd129, 16'd65406, 16'd1, 16'd2, 10'd1, 10'd1, 16'd1, 16'd1});
      send_init(dial);
      random_ticks(150, 1'b1);
      write_all(cfg_type'{16'd129, 16'd65406, 16'd63, 16'hFFFF, 10'd1, 10'd1000,
                          16'hFFFF, 16'd1999});
      send_init(dial);
      random_ticks(150, 1'b1);
      for (k = 0; k < 3; k++) begin
         write_all(random_regs());
         send_init(dial);
         random_ticks(120, 1'b1);
      end
   endtask

   initial begin
      regs = RESET_REGS;
      clear_servo();
      dial = 16'd1000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unconfigured();
      test_servo_directed();
      test_stall_and_timeout();
      test_register_checks();
      test_live_registers();
      test_random_servo();
      wait_quiet();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
